### src/dmc_pkg.sv
// Shared types and constants for the direct-mapped cache lookup block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dmc_pkg;

    localparam int ADDR_W = 10;
    localparam int BYTE_W = 8;
    localparam int COST_W = 8;
    localparam int CNT_W  = 32;

    localparam logic [COST_W-1:0] COST_RESET = 8'd10;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 104;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_ACCESS = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              access;
        logic              miss;
        logic [COST_W:0]   cost;
    } t_stat_upd;

endpackage

`default_nettype wire

### src/dmc_stats.sv
// Saturating miss, access and time counters of the cache lookup block.
// Depends on dmc_pkg for widths and the update struct.
`default_nettype none

module dmc_stats
    import dmc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_stat_upd          i_upd,
    output logic [CNT_W-1:0]        o_miss_total,
    output logic [CNT_W-1:0]        o_access_total,
    output logic [CNT_W-1:0]        o_time_total
);

    logic [CNT_W-1:0] r_miss;
    logic [CNT_W-1:0] r_access;
    logic [CNT_W-1:0] r_time;
    logic [CNT_W-1:0] n_miss;
    logic [CNT_W-1:0] n_access;
    logic [CNT_W-1:0] n_time;
    logic [CNT_W:0]   w_miss_sum;
    logic [CNT_W:0]   w_access_sum;
    logic [CNT_W:0]   w_time_sum;

    always_comb begin
        w_miss_sum   = {1'b0, r_miss} + (CNT_W+1)'(1);
        w_access_sum = {1'b0, r_access} + (CNT_W+1)'(1);
        w_time_sum   = {1'b0, r_time} + (CNT_W+1)'(i_upd.cost);
        n_miss   = r_miss;
        n_access = r_access;
        n_time   = r_time;
        if (i_upd.valid && i_upd.access) begin
            n_access = w_access_sum[CNT_W] ? '1 : w_access_sum[CNT_W-1:0];
            n_time   = w_time_sum[CNT_W] ? '1 : w_time_sum[CNT_W-1:0];
            if (i_upd.miss) begin
                n_miss = w_miss_sum[CNT_W] ? '1 : w_miss_sum[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss   <= '0;
            r_access <= '0;
            r_time   <= '0;
        end else begin
            r_miss   <= n_miss;
            r_access <= n_access;
            r_time   <= n_time;
        end
    end

    assign o_miss_total   = n_miss;
    assign o_access_total = n_access;
    assign o_time_total   = n_time;

endmodule

`default_nettype wire

### src/direct_mapped_cache_lookup_top.sv
// Top level of the direct-mapped read cache with its backing memory.
// Depends on dmc_pkg and instantiates dmc_stats.
// Flow: a load or a hit goes from idle to the done state, and a miss first passes through the
// fill state, which reads the block one byte per cycle from the single-port backing memory; in
// done the result is registered onto o_m_axis_tvalid once the output is free. One item is in
// work at a time: a new transfer is taken only after the last result has been registered.
// Reset is synchronous and active low: it invalidates all lines, clears the
// counters and sets the access cost to 10; memory contents are not cleared.
`default_nettype none

module direct_mapped_cache_lookup_top
    import dmc_pkg::*;
#(
    parameter int NUM_LINES    = 4,
    parameter int BLOCK_BYTES  = 8,
    parameter int MEMORY_BYTES = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [COST_W-1:0]      i_cfg_wdata,     // access_cost
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]   i_s_axis_tdata,  // address, load_byte, zero pad
    input  wire logic                   i_s_axis_tuser,  // mode
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [M_TDATA_W-1:0]        o_m_axis_tdata,  // read_byte, miss_total,
                                                         // access_total, time_total
    output logic                        o_m_axis_tuser   // hit
);

    localparam int OW = $clog2(BLOCK_BYTES);
    localparam int LW = $clog2(NUM_LINES);
    localparam int MW = $clog2(MEMORY_BYTES);
    localparam int IW = LW + OW;
    localparam int TW = (ADDR_W - OW - LW > 0) ? ADDR_W - OW - LW : 1;
    localparam int LINE_BYTES = NUM_LINES * BLOCK_BYTES;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FILL = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [BYTE_W-1:0] r_backing [MEMORY_BYTES];
    logic [BYTE_W-1:0] r_lines [LINE_BYTES];
    logic [BYTE_W-1:0] r_bm_q;
    logic [BYTE_W-1:0] r_lm_q;

    logic [TW-1:0]     r_tag [NUM_LINES];
    logic              r_valid [NUM_LINES];
    logic [COST_W-1:0] r_cost;

    logic              r_mode;
    logic              r_hit;
    logic [ADDR_W-1:0] r_addr;
    logic [BYTE_W-1:0] r_byte;
    logic [OW:0]       r_cnt;

    logic              r_out_valid;
    logic              r_out_hit;
    logic [BYTE_W-1:0] r_out_byte;
    logic [CNT_W-1:0]  r_out_miss;
    logic [CNT_W-1:0]  r_out_access;
    logic [CNT_W-1:0]  r_out_time;

    logic [ADDR_W-1:0] w_in_addr;
    logic [BYTE_W-1:0] w_in_byte;
    logic [TW-1:0]     w_in_tag;
    logic [LW-1:0]     w_in_line;
    logic [OW-1:0]     w_in_word;
    logic              w_in_hit;
    logic              w_accept;
    logic              w_out_free;
    logic              w_bm_we;
    logic              w_bm_re;
    logic [MW-1:0]     w_bm_addr;
    logic              w_lm_we;
    logic              w_lm_re;
    logic [OW-1:0]     w_fill_word;
    logic [TW-1:0]     w_cur_tag;
    logic [LW-1:0]     w_cur_line;
    logic [OW-1:0]     w_cur_word;
    t_stat_upd         w_upd;
    logic [CNT_W-1:0]  w_miss_total;
    logic [CNT_W-1:0]  w_access_total;
    logic [CNT_W-1:0]  w_time_total;

    assign w_in_addr = i_s_axis_tdata[ADDR_W-1:0];
    assign w_in_byte = i_s_axis_tdata[ADDR_W+BYTE_W-1:ADDR_W];
    assign w_in_tag  = TW'(w_in_addr >> (OW + LW));
    assign w_in_line = LW'(w_in_addr >> OW);
    assign w_in_word = OW'(w_in_addr);
    assign w_in_hit  = r_valid[w_in_line] && (r_tag[w_in_line] == w_in_tag);

    assign w_cur_tag  = TW'(r_addr >> (OW + LW));
    assign w_cur_line = LW'(r_addr >> OW);
    assign w_cur_word = OW'(r_addr);

    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_bm_we     = w_accept && (i_s_axis_tuser == MODE_LOAD);
    assign w_bm_re     = (r_state == S_FILL) && !r_cnt[OW];
    assign w_bm_addr   = w_bm_we ? MW'(w_in_addr)
                                 : MW'({r_addr[ADDR_W-1:OW], r_cnt[OW-1:0]});
    assign w_fill_word = OW'(r_cnt - (OW+1)'(1));
    assign w_lm_we     = (r_state == S_FILL) && (r_cnt != '0);
    assign w_lm_re     = w_accept && (i_s_axis_tuser == MODE_ACCESS) && w_in_hit;

    always_ff @(posedge i_clk) begin
        if (w_bm_we) begin
            r_backing[w_bm_addr] <= w_in_byte;
        end
        if (w_bm_re) begin
            r_bm_q <= r_backing[w_bm_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lm_we) begin
            r_lines[{w_cur_line, w_fill_word}] <= r_bm_q;
        end
        if (w_lm_re) begin
            r_lm_q <= r_lines[IW'({w_in_line, w_in_word})];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser == MODE_ACCESS && !w_in_hit) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FILL: begin
                if (r_cnt[OW]) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cost  <= COST_RESET;
            for (int i = 0; i < NUM_LINES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cost <= i_cfg_wdata;
            end
            if (r_state == S_FILL && r_cnt[OW]) begin
                r_valid[w_cur_line] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_s_axis_tuser;
            r_addr <= w_in_addr;
            r_hit  <= (i_s_axis_tuser == MODE_ACCESS) && w_in_hit;
            r_byte <= '0;
            r_cnt  <= '0;
        end
        if (r_state == S_FILL) begin
            r_cnt <= r_cnt + (OW+1)'(1);
            if (w_lm_we && w_fill_word == w_cur_word) begin
                r_byte <= r_bm_q;
            end
            if (r_cnt[OW]) begin
                r_tag[w_cur_line] <= w_cur_tag;
            end
        end
    end

    always_comb begin
        w_upd.valid  = (r_state == S_DONE) && w_out_free;
        w_upd.access = (r_mode == MODE_ACCESS);
        w_upd.miss   = !r_hit;
        w_upd.cost   = r_hit ? {1'b0, r_cost} : {r_cost, 1'b0};
    end

    dmc_stats u_stats (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_upd          (w_upd),
        .o_miss_total   (w_miss_total),
        .o_access_total (w_access_total),
        .o_time_total   (w_time_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd.valid) begin
            r_out_hit    <= r_hit;
            r_out_byte   <= r_hit ? r_lm_q : r_byte;
            r_out_miss   <= w_miss_total;
            r_out_access <= w_access_total;
            r_out_time   <= w_time_total;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tdata  = {r_out_time, r_out_access, r_out_miss, r_out_byte};

endmodule

`default_nettype wire

### src/dmc_checker.sv
// Port-level checks for the direct-mapped cache lookup top level.
// Depends on dmc_pkg; bound to direct_mapped_cache_lookup_top below.
`default_nettype none

module dmc_checker
    import dmc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    input  wire logic                   o_s_axis_tready,
    input  wire logic                   o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic [M_TDATA_W-1:0]   o_m_axis_tdata,
    input  wire logic                   o_m_axis_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output valid after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("Stalled result changed.");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("Second item taken while one is in work.");

    a_miss_le_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[39:8] <= o_m_axis_tdata[71:40])
        else $error("Miss total exceeds access total.");

endmodule

bind direct_mapped_cache_lookup_top dmc_checker u_dmc_checker (.*);

`default_nettype wire

### dv/tb_direct_mapped_cache_lookup_top.sv
// Self-checking testbench for direct_mapped_cache_lookup_top: drives loads and accesses,
// predicts every result from its own cache and memory image and compares each transfer.
// Depends on dmc_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_direct_mapped_cache_lookup_top;
    import dmc_pkg::*;

    localparam int NUM_LINES      = 4;
    localparam int BLOCK_BYTES    = 8;
    localparam int MEMORY_BYTES   = 1024;
    localparam int WORD_W         = 3;
    localparam int LINE_W         = 2;
    localparam int TAG_W          = ADDR_W - LINE_W - WORD_W;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] read_byte;
        logic [CNT_W-1:0]  miss_total;
        logic [CNT_W-1:0]  access_total;
        logic [CNT_W-1:0]  time_total;
    } t_lookup_result;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [COST_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    logic [TAG_W-1:0]     tag_store  [NUM_LINES];
    logic                 tag_valid  [NUM_LINES];
    logic [BYTE_W-1:0]    line_data  [NUM_LINES][BLOCK_BYTES];
    logic [BYTE_W-1:0]    mem_image  [MEMORY_BYTES];
    logic                 mem_loaded [MEMORY_BYTES];
    logic [COST_W-1:0]    probe_cost;
    logic [CNT_W-1:0]     misses_seen;
    logic [CNT_W-1:0]     accesses_seen;
    logic [CNT_W-1:0]     cost_total;

    t_lookup_result       expected_lookups [$];
    int unsigned          failures;
    int unsigned          items_sent;
    int unsigned          idle_pct;
    bit                   hold_req;

    direct_mapped_cache_lookup_top #(
        .NUM_LINES   (NUM_LINES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MEMORY_BYTES(MEMORY_BYTES)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = a + b;
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    function automatic void cache_predict(input logic mode, input logic [ADDR_W-1:0] addr,
                                          input logic [BYTE_W-1:0] data);
        t_lookup_result    r;
        logic [TAG_W-1:0]  tag;
        logic [LINE_W-1:0] line;
        logic [WORD_W-1:0] word;
        r = '0;
        {tag, line, word} = addr;
        if (mode == MODE_LOAD) begin
            mem_image[addr]  = data;
            mem_loaded[addr] = 1'b1;
        end else begin
            cost_total = sat_add(cost_total, CNT_W'(probe_cost));
            if (tag_valid[line] && tag_store[line] == tag) begin
                r.hit = 1'b1;
            end else begin
                misses_seen     = sat_add(misses_seen, 1);
                tag_store[line] = tag;
                tag_valid[line] = 1'b1;
                for (int i = 0; i < BLOCK_BYTES; i++) begin
                    line_data[line][i] = mem_image[{tag, line, WORD_W'(i)}];
                end
                cost_total = sat_add(cost_total, CNT_W'(probe_cost));
            end
            accesses_seen = sat_add(accesses_seen, 1);
            r.read_byte   = line_data[line][word];
        end
        r.miss_total   = misses_seen;
        r.access_total = accesses_seen;
        r.time_total   = cost_total;
        expected_lookups.push_back(r);
    endfunction

    function automatic void compare_field(input string name, input logic [CNT_W-1:0] want,
                                          input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    // Result checker: every output transfer is matched against the oldest prediction.
    always @(posedge clk) begin : result_check
        t_lookup_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_lookups.size() == 0) begin
                $error("result transfer with no lookup outstanding");
                failures++;
            end else begin
                want = expected_lookups.pop_front();
                compare_field("hit", CNT_W'(want.hit), CNT_W'(m_tuser));
                compare_field("read_byte", CNT_W'(want.read_byte), CNT_W'(m_tdata[7:0]));
                compare_field("miss_total", want.miss_total, m_tdata[39:8]);
                compare_field("access_total", want.access_total, m_tdata[71:40]);
                compare_field("time_total", want.time_total, m_tdata[103:72]);
            end
        end
    end

    initial begin : rx_ready
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_item(input logic mode, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] data);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - ADDR_W - BYTE_W){1'b0}}, data, addr};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        cache_predict(mode, addr, data);
        items_sent++;
    endtask

    // A miss reads the whole block from memory, so any byte of it not yet loaded is loaded first.
    task automatic access_with_fill(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] base;
        logic [LINE_W-1:0] line;
        base = {addr[ADDR_W-1:WORD_W], {WORD_W{1'b0}}};
        line = addr[WORD_W +: LINE_W];
        if (!(tag_valid[line] && tag_store[line] == addr[ADDR_W-1 -: TAG_W])) begin
            for (int i = 0; i < BLOCK_BYTES; i++) begin
                if (!mem_loaded[base + i]) begin
                    send_item(MODE_LOAD, base + ADDR_W'(i), BYTE_W'($urandom));
                end
            end
        end
        send_item(MODE_ACCESS, addr, BYTE_W'($urandom));
    endtask

    task automatic random_item();
        int unsigned       pick;
        logic [LINE_W-1:0] line;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(99);
        line = LINE_W'($urandom_range(NUM_LINES - 1));
        if (pick < 30) begin
            send_item(MODE_LOAD, ADDR_W'($urandom_range(MEMORY_BYTES - 1)), BYTE_W'($urandom));
        end else begin
            if (pick < 75 && tag_valid[line]) begin
                addr = {tag_store[line], line, WORD_W'($urandom_range(BLOCK_BYTES - 1))};
            end else begin
                addr = ADDR_W'($urandom_range(MEMORY_BYTES - 1));
            end
            access_with_fill(addr);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_lookups.size() != 0);
    endtask

    task automatic set_access_cost(input logic [COST_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        probe_cost = value;
    endtask

    // Runs at the reset cost: fills, hits, a stale line after a load and a conflict eviction.
    task automatic test_directed_lines();
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            send_item(MODE_LOAD, ADDR_W'(MEMORY_BYTES - BLOCK_BYTES + i),
                      (i == 0) ? 8'h00 : (i == BLOCK_BYTES - 1) ? 8'hFF : BYTE_W'($urandom));
        end
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            send_item(MODE_LOAD, ADDR_W'(24 + i), BYTE_W'($urandom));
        end
        send_item(MODE_ACCESS, 10'd1023, 8'hFF);
        send_item(MODE_ACCESS, 10'd1016, 8'h00);
        send_item(MODE_LOAD, 10'd1023, 8'h5A);
        send_item(MODE_ACCESS, 10'd1023, 8'h00);
        send_item(MODE_ACCESS, 10'd24, 8'h00);
        send_item(MODE_ACCESS, 10'd1023, 8'hFF);
        send_item(MODE_ACCESS, 10'd31, 8'h00);
    endtask

    task automatic test_random_traffic(input logic [COST_W-1:0] cost, input int unsigned count);
        set_access_cost(cost);
        repeat (count) random_item();
    endtask

    task automatic test_back_to_back(input int unsigned count);
        set_access_cost(COST_W'($urandom));
        idle_pct = 0;
        repeat (count) random_item();
        wait_drained();
        idle_pct = 18;
    endtask

    task automatic test_output_stall(input int unsigned count);
        set_access_cost(COST_RESET);
        hold_req = 1'b1;
        repeat (count) random_item();
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_LOAD;
        hold_req  = 1'b0;
        idle_pct  = 18;
        failures  = 0;
        items_sent = 0;
        probe_cost    = COST_RESET;
        misses_seen   = '0;
        accesses_seen = '0;
        cost_total    = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
            tag_store[i] = '0;
            tag_valid[i] = 1'b0;
        end
        for (int i = 0; i < MEMORY_BYTES; i++) begin
            mem_image[i]  = '0;
            mem_loaded[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_lines();
        test_random_traffic(COST_W'($urandom_range(1, 254)), 200);
        test_random_traffic(8'd0, 120);
        test_random_traffic(8'd255, 120);
        test_back_to_back(160);
        test_output_stall(40);
        test_random_traffic(COST_W'($urandom_range(1, 254)), 60);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_lookups.size() != 0) begin
            $error("%0d lookup results never arrived", expected_lookups.size());
            failures++;
        end
        $display("Summary: %0d items (%0d accesses, %0d misses) at reset, zero, full and random",
                 items_sent, accesses_seen, misses_seen);
        $display("Summary: costs, with a %0d-cycle output hold-off and a stretch without idling",
                 HOLD_CYCLES);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
